>>> sv/sfe_pkg.sv
// sfe_pkg: shared constants for the stereo feedback echo
`default_nettype none

package sfe_pkg;

    // default sizing of the delay line and samples
    localparam int unsigned DEF_MAX_DELAY   = 16384;
    localparam int unsigned DEF_SAMPLE_BITS = 24;

    // configuration port widths
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    // register widths
    localparam int unsigned DLEN_W = 15;
    localparam int unsigned FB_W   = 15;
    localparam int unsigned MIX_W  = 16;
    localparam int unsigned GAIN_W = 14;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_AMOUNT    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 8'd3;

    // register reset values
    localparam logic [DLEN_W-1:0] RST_DELAY_LENGTH  = 15'd9600;
    localparam logic [FB_W-1:0]   RST_FEEDBACK_GAIN = 15'd13107;
    localparam logic [MIX_W-1:0]  RST_MIX_AMOUNT    = 16'd16384;
    localparam logic [GAIN_W-1:0] RST_OUTPUT_GAIN   = 14'd8192;

    // unity in Q15, full wet share
    localparam logic [MIX_W-1:0] MIX_ONE = 16'h8000;

endpackage

`default_nettype wire

>>> sv/stereo_feedback_echo_top.sv
// stereo_feedback_echo_top: feedback comb echo on one shared multiplier
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------
//   in      | sink      | in_valid / in_stall   | left_in, right_in
//   out     | source    | out_valid / out_stall | left_out, right_out
//   cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// the result word is loaded into the output registers once both channels are
// done; the next frame is accepted only when the sequencer is back in idle. the pace
// is set by the single 24 by 17-bit multiplier, which forms four products per channel.
// after reset the delay memory is swept to zero, address by address, with
// in_stall high; config writes are taken at all times (cfg_ready is tied high).
// a result waiting under out_stall holds; the next frame is still accepted
// and computed, and it parks in its memory write state until the output frees.
`default_nettype none

module stereo_feedback_echo_top #(
    parameter int unsigned MAX_DELAY   = sfe_pkg::DEF_MAX_DELAY,
    parameter int unsigned SAMPLE_BITS = sfe_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // input words
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]         left_in,
    input  wire logic signed [SAMPLE_BITS-1:0]         right_in,
    // output words
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [SAMPLE_BITS-1:0]              left_out,
    output logic signed [SAMPLE_BITS-1:0]              right_out,
    // configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [sfe_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [sfe_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import sfe_pkg::*;

    localparam int unsigned SB     = SAMPLE_BITS;
    localparam int unsigned ADDR_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int unsigned LW     = (ADDR_W + 1 > DLEN_W) ? ADDR_W + 1 : DLEN_W;
    localparam int unsigned MB_W   = 17;
    localparam int unsigned P_W    = SB + MB_W;
    localparam int unsigned MW     = 2 * SB;

    // sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_READ  = 4'd1;
    localparam logic [3:0] ST_FB    = 4'd2;
    localparam logic [3:0] ST_DRY   = 4'd3;
    localparam logic [3:0] ST_WETM  = 4'd4;
    localparam logic [3:0] ST_SUM   = 4'd5;
    localparam logic [3:0] ST_GAIN  = 4'd6;
    localparam logic [3:0] ST_OUTS  = 4'd7;
    localparam logic [3:0] ST_WRITE = 4'd8;

    // clamp a wide signed value to the sample range
    function automatic logic signed [SB-1:0] sat_p(input logic signed [P_W-1:0] v);
        logic [P_W-SB:0] upper;
        upper = v[P_W-1:SB-1];
        if ((&upper) || !(|upper))
            sat_p = v[SB-1:0];
        else if (v[P_W-1])
            sat_p = {1'b1, {(SB-1){1'b0}}};
        else
            sat_p = {1'b0, {(SB-1){1'b1}}};
    endfunction

    // control registers
    logic [3:0]             state_reg, state_next;
    logic                   ch_reg, ch_next;
    logic [ADDR_W-1:0]      pos_reg, pos_next;
    logic                   clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0]      clr_addr_reg, clr_addr_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DLEN_W-1:0]      dlen_reg, dlen_next;
    logic [FB_W-1:0]        fb_reg, fb_next;
    logic [MIX_W-1:0]       mix_reg, mix_next;
    logic [GAIN_W-1:0]      gain_reg, gain_next;

    // datapath registers
    logic [ADDR_W-1:0]      cur_pos_reg, cur_pos_next;
    logic signed [SB-1:0]   x_l_reg, x_l_next;
    logic signed [SB-1:0]   x_r_reg, x_r_next;
    logic signed [P_W-1:0]  prod_reg, prod_next;
    logic signed [P_W:0]    acc_reg, acc_next;
    logic signed [SB-1:0]   wet_reg, wet_next;
    logic signed [SB-1:0]   st_l_reg, st_l_next;
    logic signed [SB-1:0]   st_r_reg, st_r_next;
    logic signed [SB-1:0]   res_l_reg, res_l_next;
    logic signed [SB-1:0]   res_r_reg, res_r_next;
    logic signed [SB-1:0]   left_out_reg, left_out_next;
    logic signed [SB-1:0]   right_out_reg, right_out_next;
    logic [MW-1:0]          rd_data_reg;

    // delay memory, both channels side by side
    logic [MW-1:0]          mem [MAX_DELAY];
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [MW-1:0]          mem_wdata;

    // combinational helpers
    logic [LW-1:0]          dlen_w;
    logic [LW-1:0]          len_eff;
    logic [LW-1:0]          pos_inc;
    logic [MIX_W-1:0]       mix_eff;
    logic [MIX_W-1:0]       dry_w;
    logic signed [SB-1:0]   x_sel;
    logic signed [SB-1:0]   d_sel;
    logic signed [SB-1:0]   wet_now;
    logic signed [SB:0]     sum_xw;
    logic signed [SB-1:0]   mixed;
    logic signed [SB-1:0]   mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic                   accept;
    logic                   can_load;

    // handshake outputs
    assign in_stall  = clr_busy_reg || (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;
    assign accept    = in_valid && !in_stall;
    assign can_load  = !out_valid_reg || !out_stall;

    // effective delay length and mix
    assign dlen_w  = LW'(dlen_reg);
    assign len_eff = (dlen_w == '0) ? LW'(1) :
                     (dlen_w > LW'(MAX_DELAY)) ? LW'(MAX_DELAY) : dlen_w;
    assign pos_inc = LW'(cur_pos_reg) + LW'(1);
    assign mix_eff = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;
    assign dry_w   = MIX_ONE - mix_eff;

    // channel operand selection
    assign x_sel   = ch_reg ? x_r_reg : x_l_reg;
    assign d_sel   = ch_reg ? rd_data_reg[MW-1:SB] : rd_data_reg[SB-1:0];
    assign wet_now = prod_reg[SB+14:15];
    assign sum_xw  = {x_sel[SB-1], x_sel} + {wet_now[SB-1], wet_now};
    assign mixed   = acc_reg[SB+14:15];

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            ST_FB:
            begin
                mul_a = d_sel;
                mul_b = {2'b00, fb_reg};
            end
            ST_DRY:
            begin
                mul_a = x_sel;
                mul_b = {1'b0, dry_w};
            end
            ST_WETM:
            begin
                mul_a = wet_reg;
                mul_b = {1'b0, mix_eff};
            end
            ST_GAIN:
            begin
                mul_a = mixed;
                mul_b = {3'b000, gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // memory write port: clearing sweep or per-frame write back
    assign mem_we    = clr_busy_reg || (state_reg == ST_WRITE);
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : cur_pos_reg;
    assign mem_wdata = clr_busy_reg ? '0 : {st_r_reg, st_l_reg};

    // sequencer and next values
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        pos_next       = pos_reg;
        clr_busy_next  = clr_busy_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        dlen_next      = dlen_reg;
        fb_next        = fb_reg;
        mix_next       = mix_reg;
        gain_next      = gain_reg;
        cur_pos_next   = cur_pos_reg;
        x_l_next       = x_l_reg;
        x_r_next       = x_r_reg;
        acc_next       = acc_reg;
        wet_next       = wet_reg;
        st_l_next      = st_l_reg;
        st_r_next      = st_r_reg;
        res_l_next     = res_l_reg;
        res_r_next     = res_r_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;

        // config writes
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DELAY_LENGTH:  dlen_next = cfg_data[DLEN_W-1:0];
                REG_FEEDBACK_GAIN: fb_next   = cfg_data[FB_W-1:0];
                REG_MIX_AMOUNT:    mix_next  = cfg_data[MIX_W-1:0];
                REG_OUTPUT_GAIN:   gain_next = cfg_data[GAIN_W-1:0];
                default:           ;
            endcase
        end

        // clearing sweep after reset
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(MAX_DELAY - 1))
                clr_busy_next = 1'b0;
        end

        // output word taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_l_next     = left_in;
                    x_r_next     = right_in;
                    ch_next      = 1'b0;
                    cur_pos_next = (LW'(pos_reg) >= len_eff) ? '0 : pos_reg;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
                state_next = ST_FB;
            ST_FB:
                state_next = ST_DRY;
            ST_DRY:
            begin
                // feedback product is ready: wet sample and store value
                wet_next = wet_now;
                if (ch_reg)
                    st_r_next = sat_p(P_W'(sum_xw));
                else
                    st_l_next = sat_p(P_W'(sum_xw));
                state_next = ST_WETM;
            end
            ST_WETM:
            begin
                acc_next   = (P_W+1)'(prod_reg);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                acc_next   = acc_reg + (P_W+1)'(prod_reg);
                state_next = ST_GAIN;
            end
            ST_GAIN:
                state_next = ST_OUTS;
            ST_OUTS:
            begin
                // scale by output gain, second channel or write back
                if (ch_reg)
                begin
                    res_r_next = sat_p(prod_reg >>> 13);
                    state_next = ST_WRITE;
                end
                else
                begin
                    res_l_next = sat_p(prod_reg >>> 13);
                    ch_next    = 1'b1;
                    state_next = ST_FB;
                end
            end
            ST_WRITE:
            begin
                if (can_load)
                begin
                    left_out_next  = res_l_reg;
                    right_out_next = res_r_reg;
                    out_valid_next = 1'b1;
                    pos_next       = (pos_inc >= len_eff) ? '0 : pos_inc[ADDR_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            pos_reg       <= '0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            dlen_reg      <= RST_DELAY_LENGTH;
            fb_reg        <= RST_FEEDBACK_GAIN;
            mix_reg       <= RST_MIX_AMOUNT;
            gain_reg      <= RST_OUTPUT_GAIN;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            pos_reg       <= pos_next;
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            dlen_reg      <= dlen_next;
            fb_reg        <= fb_next;
            mix_reg       <= mix_next;
            gain_reg      <= gain_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_pos_reg   <= cur_pos_next;
        x_l_reg       <= x_l_next;
        x_r_reg       <= x_r_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        wet_reg       <= wet_next;
        st_l_reg      <= st_l_next;
        st_r_reg      <= st_r_next;
        res_l_reg     <= res_l_next;
        res_r_reg     <= res_r_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
    end

    // delay memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (state_reg == ST_READ)
            rd_data_reg <= mem[cur_pos_reg];
    end

endmodule

`default_nettype wire

>>> sv/sfe_checker.sv
// sfe_port_props: port-level assertions for the stereo feedback echo, with bind
`default_nettype none

module sfe_port_props #(
    parameter int unsigned SAMPLE_BITS = sfe_pkg::DEF_SAMPLE_BITS
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic signed [SAMPLE_BITS-1:0]     left_out,
    input wire logic signed [SAMPLE_BITS-1:0]     right_out,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out))
        else $error("output word changed under stall");

    // an accepted frame keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an accept");

    // a new result appears only after the block was busy with a frame
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no frame in flight");

    // the memory sweep blocks input right after reset
    a_clear_after_reset: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> in_stall)
        else $error("input open before memory clear");

    // config port never back-pressures
    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind stereo_feedback_echo_top sfe_port_props #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_sfe_port_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .left_out  (left_out),
    .right_out (right_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

>>> tb/sfe_checker.sv
`timescale 1ns / 100ps
// sfe_checker: predicts and checks the output words of the stereo feedback echo
module sfe_checker #(
    parameter int unsigned MAX_DELAY = sfe_pkg::DEF_MAX_DELAY,
    parameter int unsigned SB        = sfe_pkg::DEF_SAMPLE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic signed [SB-1:0]             left_in,
    input  logic signed [SB-1:0]             right_in,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic signed [SB-1:0]             left_out,
    input  logic signed [SB-1:0]             right_out,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [sfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfe_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               fail_count,
    output int                               pending
);
    import sfe_pkg::*;

    // fraction bits of the feedback/mix and of the output gain
    localparam int FB_FRAC   = 15;
    localparam int GAIN_FRAC = 13;
    localparam longint SAMPLE_MAX = (longint'(1) << (SB - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    typedef struct packed {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
    } frame_t;

    // register copies
    logic [DLEN_W-1:0] delay_len_r;
    logic [FB_W-1:0]   fb_r;
    logic [MIX_W-1:0]  mix_r;
    logic [GAIN_W-1:0] gain_r;

    // delay lines and shared write position
    logic signed [SB-1:0] left_line  [MAX_DELAY];
    logic signed [SB-1:0] right_line [MAX_DELAY];
    int unsigned tap;

    frame_t expected_frames[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic signed [SB-1:0] clamp_sample(input longint v);
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        else if (v < SAMPLE_MIN)
            v = SAMPLE_MIN;
        return v[SB-1:0];
    endfunction

    // one channel: wet from the held sample, new line value and output
    function automatic void echo_sample(
        input  logic signed [SB-1:0] x,
        input  logic signed [SB-1:0] held,
        input  longint               mix_eff,
        output logic signed [SB-1:0] fed_back,
        output logic signed [SB-1:0] y
    );
        longint wet;
        longint mixed;
        wet      = (longint'(held) * longint'(fb_r)) >>> FB_FRAC;
        fed_back = clamp_sample(longint'(x) + wet);
        mixed    = (longint'(x) * (longint'(MIX_ONE) - mix_eff) + wet * mix_eff) >>> FB_FRAC;
        y        = clamp_sample((mixed * longint'(gain_r)) >>> GAIN_FRAC);
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        frame_t               want;
        int unsigned          span;
        longint               mix_eff;
        logic signed [SB-1:0] line_v;
        if (!rst_n) begin
            delay_len_r = RST_DELAY_LENGTH;
            fb_r        = RST_FEEDBACK_GAIN;
            mix_r       = RST_MIX_AMOUNT;
            gain_r      = RST_OUTPUT_GAIN;
            tap         = 0;
            for (int i = 0; i < MAX_DELAY; i++)
            begin
                left_line[i]  = '0;
                right_line[i] = '0;
            end
            expected_frames.delete();
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DELAY_LENGTH:  delay_len_r = cfg_data[DLEN_W-1:0];
                    REG_FEEDBACK_GAIN: fb_r        = cfg_data[FB_W-1:0];
                    REG_MIX_AMOUNT:    mix_r       = cfg_data[MIX_W-1:0];
                    REG_OUTPUT_GAIN:   gain_r      = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            // compare a delivered word with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_frames.size() == 0)
                    report_mismatch("word with none expected, left_out", 0,
                                    longint'(left_out));
                else
                begin
                    want = expected_frames.pop_front();
                    if (left_out !== want.left)
                        report_mismatch("left_out", longint'(want.left),
                                        longint'(left_out));
                    if (right_out !== want.right)
                        report_mismatch("right_out", longint'(want.right),
                                        longint'(right_out));
                end
            end

            // predict the word for an accepted frame
            if (in_valid && !in_stall)
            begin
                span = 32'(delay_len_r);
                if (span < 1)
                    span = 1;
                if (span > MAX_DELAY)
                    span = MAX_DELAY;
                mix_eff = (mix_r > MIX_ONE) ? longint'(MIX_ONE) : longint'(mix_r);
                if (tap >= span)
                    tap = 0;
                echo_sample(left_in, left_line[tap], mix_eff, line_v, want.left);
                left_line[tap] = line_v;
                echo_sample(right_in, right_line[tap], mix_eff, line_v, want.right);
                right_line[tap] = line_v;
                expected_frames.insert(expected_frames.size(), want);
                tap = tap + 1;
                if (tap >= span)
                    tap = 0;
            end
        end
        pending = expected_frames.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for the stereo feedback echo
module tb_top;
    import sfe_pkg::*;

    localparam int unsigned SB    = DEF_SAMPLE_BITS;
    localparam int ITEMS_TOTAL    = 1800;
    localparam int QUIET_TAIL     = 300;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 100000;

    localparam logic signed [SB-1:0] SAMPLE_HI = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_LO = {1'b1, {(SB-1){1'b0}}};
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_OUTPUT_GAIN + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [SB-1:0]    left_in;
    logic signed [SB-1:0]    right_in;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [SB-1:0]    left_out;
    logic signed [SB-1:0]    right_out;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit gaps_on     = 1'b1;
    bit stall_on    = 1'b1;
    bit hold_output = 1'b0;

    stereo_feedback_echo_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sfe_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .left_in    (left_in),
        .right_in   (right_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .left_out   (left_out),
        .right_out  (right_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver: random stall bursts, or one long hold on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_output = 1'b0;
                out_stall <= 1'b0;
            end
            else if (stall_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [SB-1:0] pick_sample();
        logic signed [SB-1:0] s;
        case ($urandom_range(0, 7))
            0: s = SAMPLE_HI;
            1: s = SAMPLE_LO;
            2, 3:
            begin
                s = SB'($urandom_range(0, 511));
                s = s - SB'(256);
            end
            default: s = SB'($urandom);
        endcase
        return s;
    endfunction

    // offer one frame, entered and left at a falling edge
    task automatic send_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (items_sent >= ITEMS_TOTAL - QUIET_TAIL)
        begin
            gaps_on  = 1'b0;
            stall_on = 1'b0;
        end
        @(negedge clk);
    endtask

    // stop offering, wait for every word to come back, let the block settle
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // random settings, mostly short delays so the feedback builds up
    task automatic random_settings();
        logic [CFG_DATA_W-1:0] v;
        if ($urandom_range(0, 2) != 0)
        begin
            case ($urandom_range(0, 9))
                0: v = '0;
                1: v = CFG_DATA_W'(DEF_MAX_DELAY);
                2: v = CFG_DATA_W'($urandom);
                3: v = CFG_DATA_W'($urandom_range(65, 2000));
                default: v = CFG_DATA_W'($urandom_range(1, 64));
            endcase
            write_reg(REG_DELAY_LENGTH, v);
        end
        if ($urandom_range(0, 1) != 0)
        begin
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = 16'd32767;
                2: v = CFG_DATA_W'($urandom);
                default: v = CFG_DATA_W'($urandom_range(16000, 31130));
            endcase
            write_reg(REG_FEEDBACK_GAIN, v);
        end
        if ($urandom_range(0, 1) != 0)
        begin
            case ($urandom_range(0, 4))
                0: v = '0;
                1: v = MIX_ONE;
                2: v = CFG_DATA_W'($urandom);
                default: v = CFG_DATA_W'($urandom_range(0, MIX_ONE));
            endcase
            write_reg(REG_MIX_AMOUNT, v);
        end
        if ($urandom_range(0, 1) != 0)
        begin
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = 16'd16383;
                2: v = 16'd8192;
                3: v = CFG_DATA_W'($urandom);
                default: v = CFG_DATA_W'($urandom_range(0, 16383));
            endcase
            write_reg(REG_OUTPUT_GAIN, v);
        end
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                      CFG_DATA_W'($urandom));
    endtask

    // main sequence
    initial
    begin
        int phase;
        int count;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        left_in   = '0;
        right_in  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: sample extremes and bit patterns
        send_frame(SAMPLE_HI, SAMPLE_HI);
        send_frame(SAMPLE_LO, SAMPLE_LO);
        send_frame('0, '0);
        send_frame('1, SB'(1));
        send_frame(SAMPLE_HI, SAMPLE_LO);
        send_frame(SAMPLE_LO, SAMPLE_HI);
        send_frame(24'h555555, 24'hAAAAAA);
        send_frame(24'hAAAAAA, 24'h555555);

        // one-sample delay, strongest feedback, all wet, top gain: saturation
        drain_and_settle();
        write_reg(REG_DELAY_LENGTH, 16'd1);
        write_reg(REG_FEEDBACK_GAIN, 16'd32767);
        write_reg(REG_MIX_AMOUNT, MIX_ONE);
        write_reg(REG_OUTPUT_GAIN, 16'd16383);
        repeat (2) send_frame(SAMPLE_HI, SAMPLE_LO);
        repeat (2) send_frame(SAMPLE_LO, SAMPLE_HI);

        // zero delay length, mix above full wet, zero feedback and gain
        drain_and_settle();
        write_reg(REG_DELAY_LENGTH, 16'd0);
        write_reg(REG_MIX_AMOUNT, 16'hFFFF);
        write_reg(REG_FEEDBACK_GAIN, 16'd0);
        write_reg(REG_OUTPUT_GAIN, 16'd0);
        send_frame(SAMPLE_HI, SAMPLE_LO);
        send_frame(SB'(1234), SB'(-1234));
        send_frame(SAMPLE_LO, '1);

        // delay length beyond the store, dry only, unknown register ignored
        drain_and_settle();
        write_reg(REG_DELAY_LENGTH, 16'h7FFF);
        write_reg(REG_MIX_AMOUNT, 16'd0);
        write_reg(REG_FEEDBACK_GAIN, 16'd31130);
        write_reg(REG_OUTPUT_GAIN, 16'd8192);
        write_reg(REG_SPARE_LAST, 16'hFFFF);
        repeat (5) send_frame(pick_sample(), pick_sample());

        // shortened length below the current position restarts at zero
        drain_and_settle();
        write_reg(REG_DELAY_LENGTH, 16'd3);
        write_reg(REG_MIX_AMOUNT, 16'd16384);
        repeat (5) send_frame(pick_sample(), pick_sample());

        // random phases; the quiet tail keeps frames flowing with no pauses
        phase = 0;
        while (items_sent < ITEMS_TOTAL)
        begin
            if (gaps_on)
            begin
                drain_and_settle();
                random_settings();
            end
            // one long output hold while frames keep coming
            if (phase == 2)
                hold_output = 1'b1;
            count = $urandom_range(20, 120);
            for (int k = 0; k < count && items_sent < ITEMS_TOTAL; k++)
                send_frame(pick_sample(), pick_sample());
            phase++;
        end

        drain_and_settle();
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> stereo_feedback_echo_top.f
sv/sfe_pkg.sv
sv/stereo_feedback_echo_top.sv
sv/sfe_checker.sv
tb/sfe_checker.sv
tb/tb_top.sv
